/* hdl/ptt_pkg.sv */
// shared types and constants for the percentile threshold tracker
// used by ptt_select and percentile_threshold_tracker; no dependencies
package ptt_pkg;

	localparam int WINDOW_DEF        = 100;
	localparam int UPDATE_PERIOD_DEF = 10;
	localparam int SCORE_BITS_DEF    = 16;

	// widest count and score the parameter ranges allow
	localparam int CNT_MAXW   = 9;
	localparam int SCORE_MAXW = 32;

	localparam int VAL_W = 16;

	localparam logic [VAL_W-1:0] INIT_THRESHOLD_RST = 16'd614;
	localparam logic [VAL_W-1:0] RAISE_MARGIN_RST   = 16'd82;
	localparam logic [VAL_W-1:0] THRESHOLD_FLOOR_RST = 16'd410;

	typedef enum logic [1:0] {
		REG_INIT_THRESHOLD  = 2'd0,
		REG_RAISE_MARGIN    = 2'd1,
		REG_THRESHOLD_FLOOR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                start;
		logic [CNT_MAXW-1:0] count;
	} sel_req_t;

	typedef struct packed {
		logic                  done;
		logic [SCORE_MAXW-1:0] value;
	} sel_rsp_t;

endpackage

/* hdl/ptt_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ptt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ptt_select.sv */
// bitwise radix select of the value at a given descending rank
// depends on ptt_pkg; reads the score ring through a registered read port
module ptt_select #(
	parameter int WINDOW     = ptt_pkg::WINDOW_DEF,
	parameter int SCORE_BITS = ptt_pkg::SCORE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ptt_pkg::sel_req_t         req,
	output ptt_pkg::sel_rsp_t         rsp,
	output logic [$clog2(WINDOW)-1:0] raddr,
	input  logic [SCORE_BITS-1:0]     rdata
);

	localparam int AW  = $clog2(WINDOW);
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int BW  = $clog2(SCORE_BITS);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} sel_state_t;

	sel_state_t            state_q;
	logic [CW-1:0]         m_q;
	logic [CW-1:0]         rank_q;
	logic [CW-1:0]         addr_q;
	logic [CW-1:0]         cnt_q;
	logic [BW-1:0]         bit_q;
	logic [SCORE_BITS-1:0] prefix_q;
	logic [SCORE_BITS-1:0] mask_q;
	logic                  vld_s1;
	logic                  match;
	logic                  take_one;
	logic [SCORE_BITS-1:0] prefix_next;

	assign raddr = addr_q[AW-1:0];

	// entry agrees with the prefix on the bits above and has a one here
	assign match = (((rdata ^ prefix_q) & mask_q) == '0) && rdata[bit_q];

	assign take_one = rank_q < cnt_q;

	always_comb begin
		prefix_next = prefix_q;
		prefix_next[bit_q] = take_one;
	end

	assign rsp.done  = (state_q == S_DECIDE) && (bit_q == '0);
	assign rsp.value = ptt_pkg::SCORE_MAXW'(prefix_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (req.start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= addr_q < m_q;
					if (addr_q >= m_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					vld_s1 <= 1'b0;
					state_q <= (bit_q == '0) ? S_IDLE : S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			cnt_q <= cnt_q + CW'(match);
		end
		unique case (state_q)
			S_IDLE: begin
				m_q      <= req.count[CW-1:0];
				rank_q   <= req.count[CW-1:0] >> 2;
				addr_q   <= '0;
				cnt_q    <= '0;
				bit_q    <= BW'(SCORE_BITS - 1);
				prefix_q <= '0;
				mask_q   <= '0;
			end
			S_SCAN: begin
				if (addr_q < m_q) begin
					addr_q <= addr_q + 1'b1;
				end
			end
			S_DECIDE: begin
				prefix_q      <= prefix_next;
				mask_q[bit_q] <= 1'b1;
				if (!take_one) begin
					rank_q <= rank_q - cnt_q;
				end
				cnt_q  <= '0;
				addr_q <= '0;
				bit_q  <= bit_q - 1'b1;
			end
			default: begin
				addr_q <= '0;
			end
		endcase
	end

endmodule

/* hdl/percentile_threshold_tracker.sv */
// top level: score ring, update sequencing and raise-only threshold
// depends on ptt_pkg, ptt_ram and ptt_select
// result: an item with no percentile update gives its registered result in the cycle after accept;
// an update item waits for the bitwise select over the m filled ring entries, m counting the new item
// throughput: one item per cycle between updates while the output is not stalled; no new item during an update
// reset: control state, ring position, fill count and registers cleared to defaults; ring not cleared
module percentile_threshold_tracker #(
	parameter int WINDOW        = ptt_pkg::WINDOW_DEF,
	parameter int UPDATE_PERIOD = ptt_pkg::UPDATE_PERIOD_DEF,
	parameter int SCORE_BITS    = ptt_pkg::SCORE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] score,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] threshold,
	output logic        recomputed,
	output logic        raised,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int AW  = $clog2(WINDOW);
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int PW  = $clog2(UPDATE_PERIOD + 1);
	localparam int SW  = (SCORE_BITS > 16) ? SCORE_BITS : 16;
	localparam int KW  = (SCORE_BITS > 17) ? SCORE_BITS : 17;

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_WAIT = 2'b10
	} top_state_t;

	top_state_t       state_q;
	logic [15:0]      margin_q;
	logic [15:0]      floor_q;
	logic [15:0]      th_q;
	logic [AW-1:0]    wpos_q;
	logic [PW-1:0]    phase_q;
	logic [CW-1:0]    filled_q;
	logic             out_valid_q;
	logic [15:0]      out_th_q;
	logic             out_rec_q;
	logic             out_raised_q;

	logic             accept;
	logic             wrap;
	logic [AW-1:0]    wpos_next;
	logic [PW-1:0]    phase_next;
	logic [CW-1:0]    filled_next;
	logic             do_update;
	logic [SW-1:0]    score_w;
	logic [SCORE_BITS-1:0] score_sat;
	logic [AW-1:0]    raddr;
	logic [SCORE_BITS-1:0] rdata;
	logic [SCORE_BITS-1:0] cand;
	logic [KW-1:0]    limit;
	logic [15:0]      th_raised;
	logic [15:0]      th_new;

	ptt_pkg::sel_req_t sel_req;
	ptt_pkg::sel_rsp_t sel_rsp;

	assign in_ready   = (state_q == T_IDLE) && (!out_valid_q || out_ready);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign threshold  = out_th_q;
	assign recomputed = out_rec_q;
	assign raised     = out_raised_q;

	// scores above the stored width saturate
	assign score_w   = SW'(score);
	assign score_sat = (score_w > SW'({SCORE_BITS{1'b1}})) ? {SCORE_BITS{1'b1}}
		: SCORE_BITS'(score_w);

	assign wrap        = wpos_q == AW'(WINDOW - 1);
	assign wpos_next   = wrap ? '0 : wpos_q + 1'b1;
	assign phase_next  = (wrap || phase_q == PW'(UPDATE_PERIOD - 1)) ? '0 : phase_q + 1'b1;
	assign filled_next = (filled_q == CW'(WINDOW)) ? filled_q : filled_q + 1'b1;
	assign do_update   = phase_next == '0;

	assign sel_req.start = accept && do_update;
	assign sel_req.count = ptt_pkg::CNT_MAXW'(filled_next);

	ptt_ram #(
		.WIDTH(SCORE_BITS),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.wen  (accept),
		.waddr(wpos_q),
		.wdata(score_sat),
		.raddr(raddr),
		.rdata(rdata)
	);

	ptt_select #(
		.WINDOW    (WINDOW),
		.SCORE_BITS(SCORE_BITS)
	) u_select (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sel_req),
		.rsp   (sel_rsp),
		.raddr (raddr),
		.rdata (rdata)
	);

	// raise only when the percentile clears threshold plus margin, then clamp to floor
	assign cand  = SCORE_BITS'(sel_rsp.value);
	assign limit = KW'(th_q) + KW'(margin_q);
	always_comb begin
		th_raised = (KW'(cand) > limit) ? 16'(cand) : th_q;
		th_new    = (th_raised < floor_q) ? floor_q : th_raised;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			margin_q    <= ptt_pkg::RAISE_MARGIN_RST;
			floor_q     <= ptt_pkg::THRESHOLD_FLOOR_RST;
			th_q        <= ptt_pkg::INIT_THRESHOLD_RST;
			wpos_q      <= '0;
			phase_q     <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					// the initial threshold only reaches the live one before any score
					ptt_pkg::REG_INIT_THRESHOLD: begin
						if (filled_q == '0) begin
							th_q <= cfg_wdata;
						end
					end
					ptt_pkg::REG_RAISE_MARGIN:    margin_q <= cfg_wdata;
					ptt_pkg::REG_THRESHOLD_FLOOR: floor_q  <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						wpos_q   <= wpos_next;
						phase_q  <= phase_next;
						filled_q <= filled_next;
						if (do_update) begin
							state_q <= T_WAIT;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				T_WAIT: begin
					if (sel_rsp.done) begin
						th_q        <= th_new;
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && accept && !do_update) begin
			out_th_q     <= th_q;
			out_rec_q    <= 1'b0;
			out_raised_q <= 1'b0;
		end else if (state_q == T_WAIT && sel_rsp.done) begin
			out_th_q     <= th_new;
			out_rec_q    <= 1'b1;
			out_raised_q <= th_new != th_q;
		end
	end

endmodule

/* test/tb.sv */
// testbench for percentile_threshold_tracker: directed table, then random phases
// uses ptt_pkg for register indexes and window constants; needs only the rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN         = ptt_pkg::WINDOW_DEF;
	localparam int PERIOD      = ptt_pkg::UPDATE_PERIOD_DEF;
	localparam int DIR_ROWS    = 24;
	localparam int WATCH_LIMIT = 20000;
	localparam int LONG_HOLD   = 2000;
	localparam int HOLD_AFTER  = 400;
	localparam int TAIL_CYCLES = 40;

	// no register sits at this index
	localparam logic [1:0] REG_NONE = 2'd3;

	// receiver stall modes
	localparam int RX_OPEN    = 0;
	localparam int RX_COIN    = 1;
	localparam int RX_SPARSE  = 2;
	localparam int RX_PATTERN = 3;

	typedef struct packed {
		logic [15:0] thr;
		logic        rec;
		logic        rai;
	} thr_result_t;

	typedef struct packed {
		logic [15:0] s;
		logic        typed;
		logic [15:0] want_thr;
		logic        want_rec;
		logic        want_rai;
	} stim_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [15:0] score     = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] threshold;
	logic        recomputed;
	logic        raised;
	logic        cfg_wen   = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	percentile_threshold_tracker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.score      (score),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.threshold  (threshold),
		.recomputed (recomputed),
		.raised     (raised),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	// tracker state as the testbench sees it
	logic [15:0] mdl_ring [WIN];
	int          mdl_wpos;
	int          mdl_fill;
	logic [15:0] mdl_thr;
	logic [15:0] mdl_margin;
	logic [15:0] mdl_floor;

	thr_result_t pending_thr_q [$];
	thr_result_t head_r;
	thr_result_t row_want;

	int err_cnt      = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int updates_seen = 0;
	int raises_seen  = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;
	bit valid_up     = 1'b0;

	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       rx_mode   = RX_OPEN;
	int       mode_left = 0;
	logic [7:0] rx_pat  = '0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0001, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0002, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0080, 1'b1, 16'h0000, 1'b0, 1'b0},
		'{16'h0040, 1'b1, 16'h0000, 1'b0, 1'b0},
		// first update, partial window
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		// ties; the second update lands exactly on threshold + margin
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h0100, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'hFFFE, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{16'h00FF, 1'b0, 16'h0000, 1'b0, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// descending rank r among the first m ring entries
	function automatic logic [15:0] rank_value(int m, int r);
		int gt;
		int eq;
		for (int i = 0; i < m; i++) begin
			gt = 0;
			eq = 0;
			for (int j = 0; j < m; j++) begin
				if (mdl_ring[j] > mdl_ring[i])
					gt++;
				else if (mdl_ring[j] == mdl_ring[i])
					eq++;
			end
			if (gt <= r && r < gt + eq)
				return mdl_ring[i];
		end
		return mdl_ring[0];
	endfunction

	function automatic thr_result_t predict_threshold(logic [15:0] s);
		thr_result_t res;
		logic [15:0] prev;
		logic [15:0] cand;
		logic [16:0] bar;
		prev = mdl_thr;
		res.rec = 1'b0;
		mdl_ring[mdl_wpos] = s;
		mdl_wpos = (mdl_wpos + 1) % WIN;
		if (mdl_fill < WIN)
			mdl_fill++;
		if (mdl_wpos % PERIOD == 0) begin
			cand = rank_value(mdl_fill, mdl_fill / 4);
			res.rec = 1'b1;
			bar = {1'b0, mdl_thr} + {1'b0, mdl_margin};
			if ({1'b0, cand} > bar)
				mdl_thr = cand;
			if (mdl_thr < mdl_floor)
				mdl_thr = mdl_floor;
		end
		res.thr = mdl_thr;
		res.rai = (mdl_thr != prev);
		return res;
	endfunction

	function automatic logic [15:0] rand_score(int hi);
		logic [31:0] raw;
		raw = $urandom();
		// some full-range noise so every bit toggles in every phase
		if ($urandom_range(15, 0) == 0)
			return raw[15:0];
		return 16'($urandom_range(hi, 0));
	endfunction

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			ptt_pkg::REG_INIT_THRESHOLD: begin
				if (mdl_fill == 0)
					mdl_thr = val;
			end
			ptt_pkg::REG_RAISE_MARGIN: begin
				mdl_margin = val;
			end
			ptt_pkg::REG_THRESHOLD_FLOOR: begin
				mdl_floor = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after the accept
	task automatic offer_score(input logic [15:0] s, input bit typed, input thr_result_t want);
		thr_result_t pred;
		in_valid <= 1'b1;
		score    <= s;
		valid_up = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pred = predict_threshold(s);
		pending_thr_q.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic sender_pause();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if ($urandom_range(2, 0) != 0) begin
				in_valid <= 1'b0;
				valid_up = 1'b0;
				repeat ($urandom_range(12, 1)) @(negedge clk);
			end
		end
	endtask

	task automatic drain_results();
		if (valid_up)
			in_valid <= 1'b0;
		valid_up = 1'b0;
		while (pending_thr_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input int n, input int hi);
		for (int k = 0; k < n; k++) begin
			offer_score(rand_score(hi), 1'b0, '0);
			sender_pause();
		end
		drain_results();
	endtask

	initial begin
		mdl_wpos   = 0;
		mdl_fill   = 0;
		mdl_margin = ptt_pkg::RAISE_MARGIN_RST;
		mdl_floor  = ptt_pkg::THRESHOLD_FLOOR_RST;
		mdl_thr    = ptt_pkg::INIT_THRESHOLD_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_write(REG_NONE, 16'h1234);
		// loads the live threshold too, since no score has been taken yet
		cfg_write(ptt_pkg::REG_INIT_THRESHOLD, 16'h0000);
		cfg_write(ptt_pkg::REG_RAISE_MARGIN, 16'h0000);
		cfg_write(ptt_pkg::REG_THRESHOLD_FLOOR, 16'h0000);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row_want.thr = dir_rows[i].want_thr;
			row_want.rec = dir_rows[i].want_rec;
			row_want.rai = dir_rows[i].want_rai;
			offer_score(dir_rows[i].s, dir_rows[i].typed, row_want);
			sender_pause();
		end
		drain_results();

		run_phase(310, 8191);

		cfg_write(ptt_pkg::REG_RAISE_MARGIN, 16'hFFFF);
		run_phase(160, 16383);

		// after scores this write has no effect; no initial threshold is stored
		cfg_write(ptt_pkg::REG_INIT_THRESHOLD, 16'hFFFF);
		cfg_write(ptt_pkg::REG_RAISE_MARGIN, 16'd82);
		cfg_write(ptt_pkg::REG_THRESHOLD_FLOOR, 16'd410);
		run_phase(250, 24576);

		// floor above the running threshold forces a clamp raise
		cfg_write(ptt_pkg::REG_RAISE_MARGIN, 16'd1000);
		cfg_write(ptt_pkg::REG_THRESHOLD_FLOOR, 16'd30000);
		run_phase(250, 45000);

		cfg_write(ptt_pkg::REG_RAISE_MARGIN, 16'h0000);
		cfg_write(ptt_pkg::REG_THRESHOLD_FLOOR, 16'h0000);
		cfg_write(REG_NONE, 16'hFFFF);
		run_phase(300, 65535);

		cfg_write(ptt_pkg::REG_INIT_THRESHOLD, 16'h0000);
		cfg_write(ptt_pkg::REG_THRESHOLD_FLOOR, 16'hFFFF);
		run_phase(150, 65535);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d scores sent, %0d results checked, %0d updates, %0d threshold changes",
			items_sent, results_seen, updates_seen, raises_seen);
		$display("margin and floor swept 0 to 65535, ring wrapped, one long output stall");
		if (err_cnt == 0) begin
			$display("percentile_threshold_tracker: match");
		end else begin
			$display("percentile_threshold_tracker: mismatch");
		end
		$finish;
	end

	// receiver: stall modes of random length, plus one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(3, 0);
					mode_left = $urandom_range(200, 20);
					rx_pat    = 8'($urandom());
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN: begin
						out_ready <= 1'b1;
					end
					RX_COIN: begin
						out_ready <= 1'($urandom_range(1, 0));
					end
					RX_SPARSE: begin
						out_ready <= ($urandom_range(3, 0) == 0);
					end
					default: begin
						out_ready <= rx_pat[0];
						rx_pat = {rx_pat[0], rx_pat[7:1]};
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_thr_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 40)
					$display("%0t: unexpected item: threshold %h recomputed %b raised %b",
						$time, threshold, recomputed, raised);
			end else begin
				head_r = pending_thr_q.pop_front();
				if (head_r.rec)
					updates_seen++;
				if (head_r.rai)
					raises_seen++;
				if (threshold !== head_r.thr || recomputed !== head_r.rec
						|| raised !== head_r.rai) begin
					err_cnt++;
					if (err_cnt <= 40)
						$display("%0t: expected thr %h rec %b rai %b, got thr %h rec %b rai %b",
							$time, head_r.thr, head_r.rec, head_r.rai,
							threshold, recomputed, raised);
				end
			end
		end
	end

	// ends the run when neither channel moves for too long
	initial begin
		while (idle_cycles < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCH_LIMIT);
		$display("percentile_threshold_tracker: mismatch");
		$finish;
	end

endmodule
